### rtl/button_press_sequence_detector_assert.svh
// Assertion macros shared by the button sequence detector RTL.
// Each macro expands to one labelled concurrent assertion that is
// disabled while the synchronous reset is held low.
`ifndef BUTTON_PRESS_SEQUENCE_DETECTOR_ASSERT_SVH
`define BUTTON_PRESS_SEQUENCE_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define BPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpsd assertion failed");

// Next-cycle implication.
`define BPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpsd assertion failed");

`endif

### rtl/bpsd_pkg.sv
// ----------------------------------------------------------------------------
// bpsd_pkg
// Types, constants and register map of the button press sequence detector.
// ----------------------------------------------------------------------------
package bpsd_pkg;

    // Build-time sizing
    localparam int PATTERN_SLOTS = 4;
    localparam int SEQUENCE_BITS = 24;

    // Fixed field widths
    localparam int REG_SLOTS   = 4;
    localparam int USED_SLOTS  = (PATTERN_SLOTS < REG_SLOTS) ? PATTERN_SLOTS : REG_SLOTS;
    localparam int MASK_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int BITS_W      = 24;
    localparam int TICK_W      = 8;
    localparam int PAT_W       = 32;
    localparam int PAT_COUNT_W = 8;
    localparam int PAT_BITS_W  = 24;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_INV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd7;

    // Register reset values
    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 8'd1;
    localparam logic [TICK_W-1:0] SHORT_RST    = 8'd25;
    localparam logic [TICK_W-1:0] GAP_RST      = 8'd25;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [USED_SLOTS-1:0][PAT_W-1:0] pattern;
        logic                             level_inverted;
        logic [TICK_W-1:0]                debounce_ticks;
        logic [TICK_W-1:0]                short_ticks;
        logic [TICK_W-1:0]                gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                     emit;
        logic [COUNT_W-1:0]       count;
        logic [SEQUENCE_BITS-1:0] bits;
        logic                     overflow;
    } t_seq_end;

endpackage

### rtl/bpsd_in_if.sv
// ----------------------------------------------------------------------------
// bpsd_in_if
// Sample request channel: one raw button level per request.
// ----------------------------------------------------------------------------
interface bpsd_in_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

### rtl/bpsd_out_if.sv
// ----------------------------------------------------------------------------
// bpsd_out_if
// Result channel: one request per ended press sequence.
// ----------------------------------------------------------------------------
interface bpsd_out_if
    import bpsd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  match_mask;
    logic [COUNT_W-1:0] press_count;
    logic [BITS_W-1:0]  press_bits;
    logic               overflow;

    modport source (output valid, output match_mask, output press_count,
                    output press_bits, output overflow, input ready);
    modport sink   (input valid, input match_mask, input press_count,
                    input press_bits, input overflow, output ready);
endinterface

### rtl/bpsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpsd_cfg_regs
// Configuration register file: pattern slots, polarity and tick limits.
// ----------------------------------------------------------------------------
module bpsd_cfg_regs
    import bpsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern        <= '0;
            r_cfg.level_inverted <= 1'b0;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.short_ticks    <= SHORT_RST;
            r_cfg.gap_ticks      <= GAP_RST;
        end else if (i_cfg_we) begin
            for (int s = 0; s < USED_SLOTS; s++) begin
                if (i_cfg_idx == REG_PATTERN_0 + CFG_IDX_W'(s)) begin
                    r_cfg.pattern[s] <= i_cfg_data[PAT_W-1:0];
                end
            end
            case (i_cfg_idx)
                REG_LEVEL_INV:  r_cfg.level_inverted <= i_cfg_data[0];
                REG_DEBOUNCE:   r_cfg.debounce_ticks <= i_cfg_data[TICK_W-1:0];
                REG_SHORT:      r_cfg.short_ticks    <= i_cfg_data[TICK_W-1:0];
                REG_GAP:        r_cfg.gap_ticks      <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/bpsd_seq_fsm.sv
// ----------------------------------------------------------------------------
// bpsd_seq_fsm
// Press tracker: debounce, press timing, gap timer and sequence capture.
// ----------------------------------------------------------------------------
`include "button_press_sequence_detector_assert.svh"

module bpsd_seq_fsm
    import bpsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_level,
    input  t_cfg     i_cfg,
    output t_seq_end o_end
);

    t_phase                   r_phase, n_phase;
    logic [TICK_W-1:0]        r_press_ticks, n_press_ticks;
    logic [TICK_W-1:0]        r_gap_left, n_gap_left;
    logic                     r_gap_armed, n_gap_armed;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic [SEQUENCE_BITS-1:0] r_bits, n_bits;
    logic                     r_overflow, n_overflow;

    logic              w_pressed;
    logic [TICK_W-1:0] w_ticks_inc;
    logic              w_gap_done;

    assign w_pressed   = i_level ^ i_cfg.level_inverted;
    assign w_ticks_inc = (r_press_ticks == TICK_MAX) ? TICK_MAX : r_press_ticks + 8'd1;
    assign w_gap_done  = (r_gap_left <= 8'd1);

    // Next state
    always_comb begin
        logic rec;
        logic is_long;
        rec           = 1'b0;
        is_long       = 1'b0;
        n_phase       = r_phase;
        n_press_ticks = r_press_ticks;
        n_gap_left    = r_gap_left;
        n_gap_armed   = r_gap_armed;
        n_count       = r_count;
        n_bits        = r_bits;
        n_overflow    = r_overflow;

        case (r_phase)
            PH_DEBOUNCE: begin
                n_press_ticks = w_ticks_inc;
                if (w_ticks_inc >= i_cfg.debounce_ticks) begin
                    // released before the recheck: still a short press
                    if (!w_pressed) begin
                        rec = 1'b1;
                    end else begin
                        n_phase = PH_PRESSED;
                    end
                end
            end
            PH_PRESSED: begin
                n_press_ticks = w_ticks_inc;
                if (!w_pressed) begin
                    rec     = 1'b1;
                    is_long = (w_ticks_inc >= i_cfg.short_ticks);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_pressed) begin
                    n_phase       = PH_DEBOUNCE;
                    n_press_ticks = '0;
                    n_gap_armed   = 1'b0;
                    n_gap_left    = '0;
                end else if (r_gap_armed) begin
                    if (w_gap_done) begin
                        n_count     = '0;
                        n_bits      = '0;
                        n_overflow  = 1'b0;
                        n_gap_armed = 1'b0;
                        n_gap_left  = '0;
                    end else begin
                        n_gap_left = r_gap_left - 8'd1;
                    end
                end
            end
        endcase

        if (rec) begin
            if (r_count < COUNT_W'(SEQUENCE_BITS)) begin
                n_bits  = r_bits | (SEQUENCE_BITS'(is_long) << r_count);
                n_count = r_count + 5'd1;
            end else begin
                n_overflow = 1'b1;
            end
            n_gap_left  = i_cfg.gap_ticks;
            n_gap_armed = 1'b1;
            n_phase     = PH_IDLE;
        end
    end

    // Outputs
    always_comb begin
        o_end.emit     = (r_phase != PH_DEBOUNCE) && (r_phase != PH_PRESSED) &&
                         !w_pressed && r_gap_armed && w_gap_done;
        o_end.count    = r_count;
        o_end.bits     = r_bits;
        o_end.overflow = r_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_press_ticks <= '0;
            r_gap_left    <= '0;
            r_gap_armed   <= 1'b0;
            r_count       <= '0;
            r_bits        <= '0;
            r_overflow    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_press_ticks <= n_press_ticks;
            r_gap_left    <= n_gap_left;
            r_gap_armed   <= n_gap_armed;
            r_count       <= n_count;
            r_bits        <= n_bits;
            r_overflow    <= n_overflow;
        end
    end

    `BPSD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(SEQUENCE_BITS))
    `BPSD_ASSERT_IMPL(a_overflow_full, i_clk, i_rst_n, r_overflow,
                      r_count == COUNT_W'(SEQUENCE_BITS))
    `BPSD_ASSERT_IMPL(a_gap_idle, i_clk, i_rst_n, r_gap_armed, r_phase == PH_IDLE)

endmodule

### rtl/bpsd_matcher.sv
// ----------------------------------------------------------------------------
// bpsd_matcher
// Compares an ended sequence against every pattern slot in parallel.
// ----------------------------------------------------------------------------
module bpsd_matcher
    import bpsd_pkg::*;
(
    input  t_cfg                     i_cfg,
    input  logic [COUNT_W-1:0]       i_count,
    input  logic [SEQUENCE_BITS-1:0] i_bits,
    input  logic                     i_overflow,
    output logic [MASK_W-1:0]        o_mask
);

    logic [PAT_COUNT_W-1:0] w_count;
    logic [PAT_BITS_W-1:0]  w_bits;

    assign w_count = PAT_COUNT_W'(i_count);
    assign w_bits  = PAT_BITS_W'(i_bits);

    always_comb begin
        o_mask = '0;
        for (int s = 0; s < USED_SLOTS; s++) begin
            // a slot with zero count is unused
            o_mask[s] = !i_overflow &&
                        (i_cfg.pattern[s][PAT_COUNT_W-1:0] != '0) &&
                        (i_cfg.pattern[s][PAT_COUNT_W-1:0] == w_count) &&
                        (i_cfg.pattern[s][PAT_W-1:PAT_COUNT_W] == w_bits);
        end
    end

endmodule

### rtl/button_press_sequence_detector.sv
// ----------------------------------------------------------------------------
// button_press_sequence_detector
// Classifies debounced button presses as short or long, collects them into
// a sequence and reports it with a pattern match mask once the button rests.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on i_in_ch carries one sample tick of the raw button level.
//   A result request leaves on o_out_ch only when a sequence ends (gap time
//   passed after the last release); most ticks produce no result.
//   Configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Timing:
//   A tick is held in an input register, processed from there by the press
//   tracker and any result lands in the output register. One tick is taken
//   every cycle while no sequence-ending tick is stalled (see Stall); the
//   press tracker's per-tick state update sets that rate.
// Reset:
//   Synchronous, active low. Clears the press tracker, both channel stages
//   and restores the register defaults (patterns zero, active high level,
//   debounce 1, short 25, gap 25).
// Stall:
//   While a result waits on o_out_ch, ticks that produce no result keep
//   flowing; a tick that would end a sequence is held in the input register
//   and input ready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "button_press_sequence_detector_assert.svh"

module button_press_sequence_detector
    import bpsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bpsd_in_if.sink              i_in_ch,
    bpsd_out_if.source           o_out_ch
);

    t_cfg     w_cfg;
    t_seq_end w_end;
    logic [MASK_W-1:0] w_mask;

    logic r_in_valid;
    logic r_in_level;
    logic w_consume;
    logic w_load;

    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_mask;
    logic [COUNT_W-1:0] r_out_count;
    logic [BITS_W-1:0]  r_out_bits;
    logic               r_out_overflow;

    bpsd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bpsd_seq_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_level (r_in_level),
        .i_cfg   (w_cfg),
        .o_end   (w_end)
    );

    bpsd_matcher u_match (
        .i_cfg      (w_cfg),
        .i_count    (w_end.count),
        .i_bits     (w_end.bits),
        .i_overflow (w_end.overflow),
        .o_mask     (w_mask)
    );

    // Hold a sequence-ending tick until the output register has room
    assign w_consume     = r_in_valid && (!w_end.emit || !r_out_valid || o_out_ch.ready);
    assign w_load        = w_consume && w_end.emit;
    assign i_in_ch.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_level <= i_in_ch.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_mask     <= w_mask;
            r_out_count    <= w_end.count;
            r_out_bits     <= BITS_W'(w_end.bits);
            r_out_overflow <= w_end.overflow;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.match_mask  = r_out_mask;
    assign o_out_ch.press_count = r_out_count;
    assign o_out_ch.press_bits  = r_out_bits;
    assign o_out_ch.overflow    = r_out_overflow;

    `BPSD_ASSERT_IMPL(a_overflow_no_match, i_clk, i_rst_n, r_out_valid && r_out_overflow,
                      r_out_mask == '0)
    `BPSD_ASSERT_IMPL(a_result_has_press, i_clk, i_rst_n, r_out_valid, r_out_count != '0)
    `BPSD_ASSERT_IMPL(a_result_from_tick, i_clk, i_rst_n, $rose(r_out_valid),
                      $past(r_in_valid))

endmodule

### tb/bpsd_sequence_checker.sv
// ----------------------------------------------------------------------------
// bpsd_sequence_checker
// Watches the sample, result and register ports of the button sequence
// detector, tracks presses with its own copy of the state and registers,
// and checks every result request against the oldest predicted report.
// ----------------------------------------------------------------------------
module bpsd_sequence_checker
    import bpsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bpsd_in_if                   i_in_ch,
    bpsd_out_if                  i_out_ch,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
        logic [BITS_W-1:0]  bits;
        logic               overflow;
    } seq_report_t;

    seq_report_t due_reports[$];

    // register copies
    logic [PAT_W-1:0]  pattern [USED_SLOTS];
    logic              level_inverted;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] gap_ticks;

    // press tracker
    t_phase             phase;
    logic [TICK_W-1:0]  press_ticks;
    logic [TICK_W-1:0]  gap_left;
    logic               gap_armed;
    logic [COUNT_W-1:0] press_count;
    logic [BITS_W-1:0]  press_bits;
    logic               overflow;
    int                 errors;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic store_press(input logic is_long);
        if (press_count < SEQUENCE_BITS) begin
            press_bits[press_count] = is_long;
            press_count++;
        end else begin
            overflow = 1'b1;
        end
        gap_left  = gap_ticks;
        gap_armed = 1'b1;
        phase     = PH_IDLE;
    endtask

    task automatic advance_tracker(input logic level);
        logic              pressed;
        logic [MASK_W-1:0] mask;
        pressed = level ^ level_inverted;
        case (phase)
            PH_DEBOUNCE: begin
                if (press_ticks != TICK_MAX)
                    press_ticks++;
                if (press_ticks >= debounce_ticks) begin
                    if (!pressed)
                        store_press(1'b0);
                    else
                        phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (press_ticks != TICK_MAX)
                    press_ticks++;
                if (!pressed)
                    store_press(press_ticks >= short_ticks);
            end
            default: begin
                phase = PH_IDLE;
                if (pressed) begin
                    phase       = PH_DEBOUNCE;
                    press_ticks = '0;
                    gap_armed   = 1'b0;
                    gap_left    = '0;
                end else if (gap_armed) begin
                    if (gap_left <= 1) begin
                        // sequence over: match against the slots and clear
                        mask = '0;
                        if (!overflow) begin
                            for (int i = 0; i < USED_SLOTS; i++) begin
                                if (pattern[i][PAT_COUNT_W-1:0] != '0 &&
                                    pattern[i][PAT_COUNT_W-1:0] == press_count &&
                                    pattern[i][PAT_W-1:PAT_COUNT_W] == press_bits)
                                    mask[i] = 1'b1;
                            end
                        end
                        due_reports.push_back('{mask, press_count, press_bits, overflow});
                        press_count = '0;
                        press_bits  = '0;
                        overflow    = 1'b0;
                        gap_armed   = 1'b0;
                        gap_left    = '0;
                    end else begin
                        gap_left--;
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        seq_report_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < USED_SLOTS; i++)
                pattern[i] = '0;
            level_inverted = 1'b0;
            debounce_ticks = DEBOUNCE_RST;
            short_ticks    = SHORT_RST;
            gap_ticks      = GAP_RST;
            phase          = PH_IDLE;
            press_ticks    = '0;
            gap_left       = '0;
            gap_armed      = 1'b0;
            press_count    = '0;
            press_bits     = '0;
            overflow       = 1'b0;
            errors         = 0;
            due_reports.delete();
        end else begin
            // results first: none can stem from a request taken at this edge
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (due_reports.size() == 0) begin
                    report_mismatch("result with no sequence pending, press_count",
                                    i_out_ch.press_count, 0);
                end else begin
                    want = due_reports.pop_front();
                    if (i_out_ch.match_mask !== want.mask)
                        report_mismatch("match_mask", i_out_ch.match_mask, want.mask);
                    if (i_out_ch.press_count !== want.count)
                        report_mismatch("press_count", i_out_ch.press_count, want.count);
                    if (i_out_ch.press_bits !== want.bits)
                        report_mismatch("press_bits", i_out_ch.press_bits, want.bits);
                    if (i_out_ch.overflow !== want.overflow)
                        report_mismatch("overflow", i_out_ch.overflow, want.overflow);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                advance_tracker(i_in_ch.level);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LEVEL_INV:  level_inverted = i_cfg_data[0];
                    REG_DEBOUNCE:   debounce_ticks = i_cfg_data[TICK_W-1:0];
                    REG_SHORT:      short_ticks    = i_cfg_data[TICK_W-1:0];
                    REG_GAP:        gap_ticks      = i_cfg_data[TICK_W-1:0];
                    default: begin
                        if (i_cfg_idx < REG_PATTERN_0 + USED_SLOTS)
                            pattern[i_cfg_idx - REG_PATTERN_0] = i_cfg_data;
                    end
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= due_reports.size();
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the button sequence detector with sample ticks shaped into short and
// long presses, bounces and over-long sequences, under several register
// settings, with random idling on both channels; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;
    import bpsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TICK_TARGET = 1950;
    localparam int SEQ_TARGET  = 24;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bpsd_in_if  in_ch();
    bpsd_out_if out_ch();

    // stimulus-side view of the registers, used to shape presses and to write the pattern slots
    logic             cur_al;
    int               cur_db;
    int               cur_sh;
    int               cur_gp;
    logic [PAT_W-1:0] pat [USED_SLOTS];

    logic quiet;
    int   ticks_sent  = 0;
    int   seqs_played = 0;
    int   cycles      = 0;
    int   phase_no;
    int   errors;
    int   pending;

    button_press_sequence_detector DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    bpsd_sequence_checker seq_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk)
        out_ch.ready <= quiet || ($urandom_range(99) >= 28);

    // valid stays high on return so back-to-back requests need no gap
    task automatic drive_tick(input logic level);
        while (!quiet && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.level <= level;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        ticks_sent++;
    endtask

    task automatic hold_level(input logic pressed, input int n);
        repeat (n)
            drive_tick(pressed ^ cur_al);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_registers(input logic al, input int db, input int sh, input int gp);
        cur_al = al;
        cur_db = db;
        cur_sh = sh;
        cur_gp = gp;
        for (int i = 0; i < USED_SLOTS; i++)
            write_reg(CFG_IDX_W'(REG_PATTERN_0 + i), pat[i]);
        write_reg(REG_LEVEL_INV, CFG_W'(al));
        write_reg(REG_DEBOUNCE, CFG_W'(db));
        write_reg(REG_SHORT, CFG_W'(sh));
        write_reg(REG_GAP, CFG_W'(gp));
        cfg_we <= 1'b0;
    endtask

    task automatic new_patterns();
        int               c;
        int               r;
        logic [BITS_W-1:0] b;
        for (int i = 0; i < USED_SLOTS; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                c = $urandom_range(6, 1);
            else if (r < 85)
                c = $urandom_range(24, 7);
            else if (r < 95)
                c = 0;
            else
                c = $urandom_range(255, 25);
            b = BITS_W'($urandom);
            // mostly keep the bits matchable: drop those past the count
            if (c < BITS_W && $urandom_range(9) != 0)
                b &= ~({BITS_W{1'b1}} << c);
            pat[i] = {b, PAT_COUNT_W'(c)};
        end
        if ($urandom_range(4) == 0)
            pat[USED_SLOTS-1] = pat[0];
    endtask

    // Play presses of the given kinds, each released within the gap so the
    // sequence goes on, then rest long enough to end it.
    task automatic play_sequence(input int presses, input logic [BITS_W-1:0] kinds);
        int   db;
        int   gp;
        int   n;
        int   rec;
        int   rel;
        int   shortmax;
        logic is_long;
        db = (cur_db == 0) ? 1 : cur_db;
        gp = (cur_gp == 0) ? 1 : cur_gp;
        shortmax = (cur_sh - 1 > db) ? cur_sh - 1 : db;
        if (shortmax > 16)
            shortmax = 16;
        for (int k = 0; k < presses; k++) begin
            is_long = (k < BITS_W) ? kinds[k] : 1'($urandom_range(1));
            if (is_long) begin
                n = ((cur_sh > db) ? cur_sh : db + 1) + $urandom_range(6);
                if ($urandom_range(39) == 0)
                    n += 250;
            end else begin
                n = $urandom_range(shortmax, 1);
            end
            hold_level(1'b1, n);
            // a press released before the debounce check is recorded at the check
            rec = (n > db) ? n : db;
            if (k == presses - 1)
                rel = rec - n + gp + 1 + $urandom_range(3);
            else
                rel = rec - n + 1 + $urandom_range((gp > 2) ? gp - 2 : 0);
            hold_level(1'b0, rel);
        end
        seqs_played++;
    endtask

    initial begin
        int r;
        int slot;
        int c;
        in_ch.valid  = 1'b0;
        in_ch.level  = 1'b0;
        out_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        quiet        = 1'b0;
        cur_al       = 1'b0;
        cur_db       = DEBOUNCE_RST;
        cur_sh       = SHORT_RST;
        cur_gp       = GAP_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: one short press, no slot in use
        play_sequence(1, '0);
        wait_drained();

        // one short; short then long (two slots agree); a slot with no count
        pat[0] = {24'h000000, 8'd1};
        pat[1] = {24'h000002, 8'd2};
        pat[2] = {24'h000002, 8'd0};
        pat[3] = {24'h000002, 8'd2};
        load_registers(1'b0, 1, 2, 1);
        play_sequence(1, 24'h000000);
        play_sequence(2, 24'h000002);
        play_sequence(1, 24'h000001);

        for (phase_no = 0;
             phase_no < 3 || ticks_sent < TICK_TARGET || seqs_played < SEQ_TARGET;
             phase_no++) begin
            wait_drained();
            quiet = (phase_no == 0);
            new_patterns();
            case (phase_no)
                0: load_registers(1'b0, $urandom_range(3, 1), $urandom_range(8, 2),
                                  $urandom_range(5, 1));
                1: begin
                    for (int i = 0; i < USED_SLOTS; i++)
                        pat[i] = '1;
                    load_registers(1'b1, 255, 255, 255);
                end
                2: load_registers(1'b0, 1, 1, 1);
                default: load_registers(1'($urandom_range(1)), $urandom_range(4, 1),
                                        $urandom_range(12, 1), $urandom_range(6, 1));
            endcase

            if (phase_no == 1) begin
                play_sequence($urandom_range(2, 1), BITS_W'($urandom));
            end else begin
                repeat (10) begin
                    r = $urandom_range(99);
                    if (r < 12) begin
                        // bounce noise, then rest long enough to close anything open
                        repeat ($urandom_range(12, 2))
                            hold_level(1'($urandom_range(1)), $urandom_range(4, 1));
                        hold_level(1'b0, cur_db + cur_gp + 3);
                    end else if (r < 18) begin
                        play_sequence($urandom_range(28, 25), BITS_W'($urandom));
                    end else if (r < 60) begin
                        slot = $urandom_range(USED_SLOTS - 1);
                        c = pat[slot][PAT_COUNT_W-1:0];
                        if (c >= 1 && c <= BITS_W)
                            play_sequence(c, pat[slot][PAT_W-1:PAT_COUNT_W]);
                        else
                            play_sequence($urandom_range(4, 1), BITS_W'($urandom));
                    end else if (r < 85) begin
                        play_sequence($urandom_range(6, 1), BITS_W'($urandom));
                    end else begin
                        play_sequence($urandom_range(24, 7), BITS_W'($urandom));
                    end
                    // hold the sender until every result is out
                    if ($urandom_range(5) == 0)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/bpsd_pkg.sv
rtl/bpsd_in_if.sv
rtl/bpsd_out_if.sv
rtl/bpsd_cfg_regs.sv
rtl/bpsd_seq_fsm.sv
rtl/bpsd_matcher.sv
rtl/button_press_sequence_detector.sv
tb/bpsd_sequence_checker.sv
tb/testbench.sv
